FILE: hdl/cvs_pkg.sv
// cvs_pkg: shared constants, types and the controller state enum for the cell voltage store.
// No dependencies; imported by every module of the block but cvs_ram.
package cvs_pkg;

   localparam int MODULES_DEF      = 8;
   localparam int CELLS_PER_MODULE = 15;

   localparam int MV_W      = 13;
   localparam int POS_W     = 7;
   localparam int RAW_W     = 16;
   localparam int SPREAD_W  = 14;
   localparam int MOD_CNT_W = 4;
   localparam int SLOT_CNT_W = 4;

   localparam logic             MODE_STORE = 1'b0;
   localparam logic             MODE_SCAN  = 1'b1;

   localparam logic [RAW_W-1:0] RAW_INVALID  = 16'hFFFF;
   localparam logic [RAW_W-1:0] RAW_ZERO     = 16'h0000;
   localparam logic [2:0]       GROUP_COUNT  = 3'd5;
   localparam logic [1:0]       SLOT_MAX     = 2'd2;
   localparam logic [MV_W-1:0]  PRESENT_MV   = 13'd10;
   localparam logic [MV_W-1:0]  MIN_START_MV = 13'd5000;
   localparam logic [SLOT_CNT_W-1:0] LAST_SCAN_SLOT = 4'd13;

   // raw*2/25 == (raw * RECIP) >> RECIP_SHIFT, exact for every 16-bit raw
   localparam int               RECIP_W     = 22;
   localparam logic [RECIP_W-1:0] RECIP     = 22'd2684355;
   localparam int               RECIP_SHIFT = 25;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STORE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic clear;
      logic sample;
   } scan_ctl_type;

   typedef struct packed {
      logic [MV_W-1:0]  max_mv;
      logic [MV_W-1:0]  min_mv;
      logic [POS_W-1:0] max_pos;
      logic [POS_W-1:0] min_pos;
      logic [POS_W-1:0] count;
   } summary_type;

endpackage

FILE: hdl/cvs_ram.sv
// cvs_ram: generic simple dual-port RAM, one write port, one read port, registered read.
// No dependencies.
module cvs_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 120,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/cvs_store.sv
// cvs_store: scales a raw reading to millivolts, checks it and forms the store address.
// Depends on cvs_pkg.
module cvs_store import cvs_pkg::*; #(
   parameter int MODULES = MODULES_DEF,
   parameter int AW      = $clog2(MODULES * CELLS_PER_MODULE)
) (
   input  logic [2:0]       group,
   input  logic [2:0]       module_req,
   input  logic [1:0]       slot,
   input  logic [RAW_W-1:0] raw_value,
   output logic [MV_W-1:0]  mv,
   output logic             ok,
   output logic [AW-1:0]    addr
);

   logic [RAW_W+RECIP_W-1:0] prod;
   logic [6:0]               idx;
   logic                     in_range;
   logic                     bad_raw;

   assign prod = (RAW_W+RECIP_W)'(raw_value) * (RAW_W+RECIP_W)'(RECIP);
   assign mv   = prod[RECIP_SHIFT +: MV_W];

   assign in_range = (group < GROUP_COUNT) && (slot <= SLOT_MAX)
                   && ({1'b0, module_req} < MOD_CNT_W'(MODULES));
   assign bad_raw  = (raw_value == RAW_INVALID)
                   || ((group == 3'd0) && (raw_value == RAW_ZERO));
   assign ok       = in_range && !bad_raw;

   // module * 15 + group * 3 + slot, at most 119 for an in-range word
   assign idx  = 7'(module_req) * 7'(CELLS_PER_MODULE) + 7'(group) * 7'd3 + 7'(slot);
   assign addr = idx[AW-1:0];

endmodule

FILE: hdl/cvs_scan.sv
// cvs_scan: running max/min/count over the cell words read back during a scan.
// Depends on cvs_pkg.
module cvs_scan import cvs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  scan_ctl_type      ctl,
   input  logic [MV_W-1:0]   rd_data,
   input  logic              rd_vld,
   output summary_type       summary
);

   logic [MV_W-1:0]  max_ff, max_in;
   logic [MV_W-1:0]  min_ff, min_in;
   logic [POS_W-1:0] max_pos_ff, max_pos_in;
   logic [POS_W-1:0] min_pos_ff, min_pos_in;
   logic [POS_W-1:0] cnt_ff, cnt_in;
   logic [MV_W-1:0]  v;
   logic             present;

   // never-written cells read as zero
   assign v       = rd_vld ? rd_data : '0;
   assign present = v > PRESENT_MV;

   always_comb begin
      max_in     = max_ff;
      min_in     = min_ff;
      max_pos_in = max_pos_ff;
      min_pos_in = min_pos_ff;
      cnt_in     = cnt_ff;
      if (ctl.clear) begin
         max_in = '0;
         min_in = MIN_START_MV;
         cnt_in = '0;
      end else if (ctl.sample && present) begin
         // strict compares: first occurrence wins
         if (v > max_ff) begin
            max_in     = v;
            max_pos_in = cnt_ff;
         end
         if (v < min_ff) begin
            min_in     = v;
            min_pos_in = cnt_ff;
         end
         cnt_in = cnt_ff + 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff     <= '0;
         min_ff     <= MIN_START_MV;
         max_pos_ff <= '0;
         min_pos_ff <= '0;
         cnt_ff     <= '0;
      end else begin
         max_ff     <= max_in;
         min_ff     <= min_in;
         max_pos_ff <= max_pos_in;
         min_pos_ff <= min_pos_in;
         cnt_ff     <= cnt_in;
      end
   end

   assign summary.max_mv  = max_ff;
   assign summary.min_mv  = min_ff;
   assign summary.max_pos = max_pos_ff;
   assign summary.min_pos = min_pos_ff;
   assign summary.count   = cnt_ff;

endmodule

FILE: hdl/cell_voltage_store_minmax_top.sv
// Cell voltage store with min/max scan. A store word (mode 0) passes through ST_STORE,
// which registers its result onto the rsp_ ports. A scan word (mode 1) reads the cell
// RAM one entry per cycle over 14 slots of each of N = min(scan_modules, MODULES)
// modules, then passes through ST_FINISH, which registers the summary onto the rsp_ ports.
// Every result is held for exactly one cycle with rsp_valid high and must be taken then;
// the block cannot be stalled from the output. Unwritten cells read as 0 through per-entry
// valid bits cleared by reset.
// Depends on cvs_pkg, cvs_ram, cvs_store and cvs_scan.
module cell_voltage_store_minmax_top import cvs_pkg::*; #(
   parameter int MODULES = MODULES_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_mode,
   input  logic [2:0]                 req_group,
   input  logic [2:0]                 req_module_req,
   input  logic [1:0]                 req_slot,
   input  logic [RAW_W-1:0]           req_raw_value,
   output logic                       rsp_valid,
   output logic [MV_W-1:0]            rsp_stored_mv,
   output logic                       rsp_accepted,
   output logic [MV_W-1:0]            rsp_max_mv,
   output logic [MV_W-1:0]            rsp_min_mv,
   output logic [POS_W-1:0]           rsp_max_position,
   output logic [POS_W-1:0]           rsp_min_position,
   output logic [POS_W-1:0]           rsp_present_count,
   output logic signed [SPREAD_W-1:0] rsp_spread_mv,
   input  logic                       csr_we,
   input  logic [2:0]                 csr_wdata
);

   localparam int DEPTH = MODULES * CELLS_PER_MODULE;
   localparam int AW    = $clog2(DEPTH);

   state_type state_ff, state_in;

   logic                 accept;
   logic [2:0]           scan_modules_ff;
   logic [2:0]           group_ff;
   logic [2:0]           module_ff;
   logic [1:0]           slot_ff;
   logic [RAW_W-1:0]     raw_ff;

   logic [MV_W-1:0]      st_mv;
   logic                 st_ok;
   logic [AW-1:0]        st_addr;
   logic                 wr_en;

   logic [DEPTH-1:0]     vld_ff;
   logic                 rd_vld_ff;
   logic                 rd_pend_ff, rd_pend_in;
   logic [AW-1:0]        addr_ff, addr_in;
   logic [SLOT_CNT_W-1:0] scan_slot_ff, scan_slot_in;
   logic [MOD_CNT_W-1:0] mod_ff, mod_in;
   logic [MOD_CNT_W-1:0] mod_count;
   logic                 issue;
   logic [MV_W-1:0]      rd_data;

   scan_ctl_type         scan_ctl;
   summary_type          summary;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [MV_W-1:0]            stored_mv_ff, stored_mv_in;
   logic                       accepted_ff, accepted_in;
   logic [MV_W-1:0]            max_mv_ff, max_mv_in;
   logic [MV_W-1:0]            min_mv_ff, min_mv_in;
   logic [POS_W-1:0]           max_pos_ff, max_pos_in;
   logic [POS_W-1:0]           min_pos_ff, min_pos_in;
   logic [POS_W-1:0]           count_ff, count_in;
   logic [SPREAD_W-1:0]        spread_ff, spread_in;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_modules_ff <= 3'd2;
      end else if (csr_we) begin
         scan_modules_ff <= csr_wdata;
      end
   end

   // request word capture
   always_ff @(posedge clock) begin
      if (accept) begin
         group_ff  <= req_group;
         module_ff <= req_module_req;
         slot_ff   <= req_slot;
         raw_ff    <= req_raw_value;
      end
   end

   cvs_store #(
      .MODULES (MODULES),
      .AW      (AW)
   ) u_store (
      .group      (group_ff),
      .module_req (module_ff),
      .slot       (slot_ff),
      .raw_value  (raw_ff),
      .mv         (st_mv),
      .ok         (st_ok),
      .addr       (st_addr)
   );

   assign wr_en = (state_ff == ST_STORE) && st_ok;

   // scan walk: modules saturate at MODULES, slot 14 is skipped
   assign mod_count = ({1'b0, scan_modules_ff} > MOD_CNT_W'(MODULES))
                    ? MOD_CNT_W'(MODULES) : {1'b0, scan_modules_ff};
   assign issue     = (state_ff == ST_SCAN) && (mod_ff != mod_count);

   cvs_ram #(
      .WIDTH (MV_W),
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (st_addr),
      .wr_data (st_mv),
      .rd_en   (issue),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   // valid bits stand in for the all-zero reset of the store
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[st_addr] <= 1'b1;
         end
         if (issue) begin
            rd_vld_ff <= vld_ff[addr_ff];
         end
      end
   end

   assign scan_ctl.clear  = accept && (req_mode == MODE_SCAN);
   assign scan_ctl.sample = rd_pend_ff;

   cvs_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .ctl     (scan_ctl),
      .rd_data (rd_data),
      .rd_vld  (rd_vld_ff),
      .summary (summary)
   );

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      scan_slot_in = scan_slot_ff;
      mod_in       = mod_ff;
      rd_pend_in   = 1'b0;
      rsp_valid_in = 1'b0;
      stored_mv_in = stored_mv_ff;
      accepted_in  = accepted_ff;
      max_mv_in    = max_mv_ff;
      min_mv_in    = min_mv_ff;
      max_pos_in   = max_pos_ff;
      min_pos_in   = min_pos_ff;
      count_in     = count_ff;
      spread_in    = spread_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               addr_in      = '0;
               scan_slot_in = '0;
               mod_in       = '0;
               state_in     = (req_mode == MODE_SCAN) ? ST_SCAN : ST_STORE;
            end
         end
         ST_STORE: begin
            rsp_valid_in = 1'b1;
            stored_mv_in = st_ok ? st_mv : '0;
            accepted_in  = st_ok;
            max_mv_in    = '0;
            min_mv_in    = '0;
            max_pos_in   = '0;
            min_pos_in   = '0;
            count_in     = '0;
            spread_in    = '0;
            state_in     = ST_IDLE;
         end
         ST_SCAN: begin
            if (issue) begin
               rd_pend_in = 1'b1;
               if (scan_slot_ff == LAST_SCAN_SLOT) begin
                  scan_slot_in = '0;
                  mod_in       = mod_ff + MOD_CNT_W'(1);
                  addr_in      = addr_ff + AW'(2);
               end else begin
                  scan_slot_in = scan_slot_ff + SLOT_CNT_W'(1);
                  addr_in      = addr_ff + AW'(1);
               end
            end else if (!rd_pend_ff) begin
               // last word has been folded into the summary
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            rsp_valid_in = 1'b1;
            stored_mv_in = '0;
            accepted_in  = 1'b0;
            max_mv_in    = summary.max_mv;
            min_mv_in    = summary.min_mv;
            max_pos_in   = summary.max_pos;
            min_pos_in   = summary.min_pos;
            count_in     = summary.count;
            spread_in    = {1'b0, summary.max_mv} - {1'b0, summary.min_mv};
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         addr_ff      <= '0;
         scan_slot_ff <= '0;
         mod_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         scan_slot_ff <= scan_slot_in;
         mod_ff       <= mod_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stored_mv_ff <= stored_mv_in;
      accepted_ff  <= accepted_in;
      max_mv_ff    <= max_mv_in;
      min_mv_ff    <= min_mv_in;
      max_pos_ff   <= max_pos_in;
      min_pos_ff   <= min_pos_in;
      count_ff     <= count_in;
      spread_ff    <= spread_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_stored_mv     = stored_mv_ff;
   assign rsp_accepted      = accepted_ff;
   assign rsp_max_mv        = max_mv_ff;
   assign rsp_min_mv        = min_mv_ff;
   assign rsp_max_position  = max_pos_ff;
   assign rsp_min_position  = min_pos_ff;
   assign rsp_present_count = count_ff;
   assign rsp_spread_mv     = spread_ff;

endmodule

FILE: dv/cell_voltage_store_minmax_scoreboard.sv
// Scoreboard for the cell voltage store: watches the start/busy and rsp_ channels and csr writes.
// Keeps its own copy of the cell store and scan summary and compares every response word.
// Depends on cvs_pkg.
module cell_voltage_store_minmax_scoreboard import cvs_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       busy,
   input  logic                       req_mode,
   input  logic [2:0]                 req_group,
   input  logic [2:0]                 req_module_req,
   input  logic [1:0]                 req_slot,
   input  logic [RAW_W-1:0]           req_raw_value,
   input  logic                       rsp_valid,
   input  logic [MV_W-1:0]            rsp_stored_mv,
   input  logic                       rsp_accepted,
   input  logic [MV_W-1:0]            rsp_max_mv,
   input  logic [MV_W-1:0]            rsp_min_mv,
   input  logic [POS_W-1:0]           rsp_max_position,
   input  logic [POS_W-1:0]           rsp_min_position,
   input  logic [POS_W-1:0]           rsp_present_count,
   input  logic signed [SPREAD_W-1:0] rsp_spread_mv,
   input  logic                       csr_we,
   input  logic [2:0]                 csr_wdata,
   output int                         mismatch_count,
   output int                         words_in_flight
);

   typedef struct packed {
      logic [MV_W-1:0]     stored_mv;
      logic                accepted;
      logic [MV_W-1:0]     max_mv;
      logic [MV_W-1:0]     min_mv;
      logic [POS_W-1:0]    max_position;
      logic [POS_W-1:0]    min_position;
      logic [POS_W-1:0]    present_count;
      logic [SPREAD_W-1:0] spread_mv;
   } cell_report_type;

   logic [MV_W-1:0]  cell_mv [MODULES_DEF*CELLS_PER_MODULE];
   logic [POS_W-1:0] max_held;
   logic [POS_W-1:0] min_held;
   logic [2:0]       modules_scanned;
   cell_report_type  reports_due [$];
   int               fail_total = 0;
   int               due_count = 0;

   assign mismatch_count  = fail_total;
   assign words_in_flight = due_count;

   function automatic void compare_field(string field, int want_v, int got_v);
      if (want_v != got_v) begin
         $display("%0t %s expected %0d actual %0d", $time, field, want_v, got_v);
         fail_total++;
      end
   endfunction

   always @(posedge clock) begin : watch
      cell_report_type want;
      int unsigned     hi, lo, seen, idx, mv, mods;
      if (reset) begin
         for (int i = 0; i < MODULES_DEF*CELLS_PER_MODULE; i++) cell_mv[i] = '0;
         max_held = '0;
         min_held = '0;
         modules_scanned = 3'd2;
         reports_due.delete();
      end else begin
         if (rsp_valid) begin
            if (reports_due.size() == 0) begin
               $display("%0t unexpected response word: expected none, actual max %0d min %0d",
                        $time, rsp_max_mv, rsp_min_mv);
               fail_total++;
            end else begin
               want = reports_due.pop_front();
               compare_field("stored_mv", int'(want.stored_mv), int'(rsp_stored_mv));
               compare_field("accepted", int'(want.accepted), int'(rsp_accepted));
               compare_field("max_mv", int'(want.max_mv), int'(rsp_max_mv));
               compare_field("min_mv", int'(want.min_mv), int'(rsp_min_mv));
               compare_field("max_position", int'(want.max_position),
                             int'(rsp_max_position));
               compare_field("min_position", int'(want.min_position),
                             int'(rsp_min_position));
               compare_field("present_count", int'(want.present_count),
                             int'(rsp_present_count));
               compare_field("spread_mv", int'($signed(want.spread_mv)), int'(rsp_spread_mv));
            end
         end
         if (csr_we) modules_scanned = csr_wdata;
         if (start && !busy) begin
            want = '0;
            if (req_mode == MODE_STORE) begin
               mv = (int'(req_raw_value) * 2) / 25;
               if (req_group < GROUP_COUNT && req_slot <= SLOT_MAX &&
                   req_raw_value != RAW_INVALID &&
                   !(req_group == 3'd0 && req_raw_value == RAW_ZERO)) begin
                  idx = int'(req_module_req) * CELLS_PER_MODULE + int'(req_group) * 3 +
                        int'(req_slot);
                  cell_mv[idx] = mv[MV_W-1:0];
                  want.stored_mv = mv[MV_W-1:0];
                  want.accepted = 1'b1;
               end
            end else begin
               hi = 0;
               lo = 32'(MIN_START_MV);
               seen = 0;
               mods = (int'(modules_scanned) > MODULES_DEF) ? MODULES_DEF
                                                            : int'(modules_scanned);
               // slot 14 of each module is never walked
               for (int m = 0; m < mods; m++) begin
                  for (int s = 0; s <= int'(LAST_SCAN_SLOT); s++) begin
                     mv = 32'(cell_mv[m*CELLS_PER_MODULE + s]);
                     if (mv > 32'(PRESENT_MV)) begin
                        // strict compares keep the first occurrence
                        if (mv > hi) begin
                           hi = mv;
                           max_held = seen[POS_W-1:0];
                        end
                        if (mv < lo) begin
                           lo = mv;
                           min_held = seen[POS_W-1:0];
                        end
                        seen++;
                     end
                  end
               end
               want.max_mv = hi[MV_W-1:0];
               want.min_mv = lo[MV_W-1:0];
               want.max_position = max_held;
               want.min_position = min_held;
               want.present_count = seen[POS_W-1:0];
               want.spread_mv = SPREAD_W'(hi - lo);
            end
            reports_due.push_back(want);
         end
      end
      due_count = reports_due.size();
   end

endmodule

FILE: dv/cell_voltage_store_minmax_top_test.sv
// Testbench top for cell_voltage_store_minmax_top: clock, reset, store and scan words, csr writes.
// Depends on cvs_pkg, the block's RTL and cell_voltage_store_minmax_scoreboard.
module cell_voltage_store_minmax_top_test;
   import cvs_pkg::*;

   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int PHASES         = 7;
   localparam int WORDS_PER_PHASE = 150;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic                       req_mode = MODE_STORE;
   logic [2:0]                 req_group = '0;
   logic [2:0]                 req_module_req = '0;
   logic [1:0]                 req_slot = '0;
   logic [RAW_W-1:0]           req_raw_value = '0;
   logic                       rsp_valid;
   logic [MV_W-1:0]            rsp_stored_mv;
   logic                       rsp_accepted;
   logic [MV_W-1:0]            rsp_max_mv;
   logic [MV_W-1:0]            rsp_min_mv;
   logic [POS_W-1:0]           rsp_max_position;
   logic [POS_W-1:0]           rsp_min_position;
   logic [POS_W-1:0]           rsp_present_count;
   logic signed [SPREAD_W-1:0] rsp_spread_mv;
   logic                       csr_we = 1'b0;
   logic [2:0]                 csr_wdata = '0;
   int                         mismatches;
   int                         in_flight;
   int unsigned                cycle_count = 0;
   int                         steady_left = 0;

   always #6 clock = ~clock;

   cell_voltage_store_minmax_top dut (.*);

   cell_voltage_store_minmax_scoreboard scoreboard (
      .mismatch_count(mismatches),
      .words_in_flight(in_flight),
      .*
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // called at a falling edge; returns at the falling edge after the word is taken
   task automatic send_word(logic mode, logic [2:0] grp, logic [2:0] mdl, logic [1:0] slt,
                            logic [RAW_W-1:0] raw);
      int r;
      int gap;
      gap = 0;
      if (steady_left > 0) begin
         steady_left--;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 3) steady_left = $urandom_range(20, 60);
         else if (r < 60) gap = 0;
         else if (r < 92) gap = $urandom_range(1, 3);
         else gap = $urandom_range(8, 40);
      end
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_mode = mode;
      req_group = grp;
      req_module_req = mdl;
      req_slot = slt;
      req_raw_value = raw;
      start = 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic write_scan_modules(logic [2:0] value);
      start = 1'b0;
      while (in_flight != 0 || busy) @(negedge clock);
      csr_wdata = value;
      csr_we = 1'b1;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   initial begin
      int               counted;
      int               r;
      logic             m;
      logic [2:0]       g;
      logic [2:0]       md;
      logic [1:0]       s;
      logic [RAW_W-1:0] raw;
      logic [2:0]       cfg;
      bit               useful;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty store, then invalid readings and the extremes
      send_word(MODE_SCAN, 3'd0, 3'd0, 2'd0, 16'h0000);
      send_word(MODE_STORE, 3'd0, 3'd0, 2'd0, RAW_ZERO);
      send_word(MODE_STORE, 3'd1, 3'd0, 2'd0, RAW_INVALID);
      send_word(MODE_STORE, 3'd4, 3'd7, 2'd2, 16'hFFFE);
      send_word(MODE_STORE, 3'd0, 3'd0, 2'd1, 16'hFFFE);
      // only cell above the min start value: min stays 5000, positions held
      send_word(MODE_SCAN, 3'd7, 3'd7, 2'd3, 16'hFFFF);
      // presence threshold sits between raw 137 and 138
      send_word(MODE_STORE, 3'd1, 3'd0, 2'd0, 16'd137);
      send_word(MODE_STORE, 3'd1, 3'd0, 2'd1, 16'd138);
      send_word(MODE_STORE, 3'd2, 3'd1, 2'd0, 16'd138);
      send_word(MODE_STORE, 3'd4, 3'd0, 2'd2, 16'h0001);
      send_word(MODE_STORE, 3'd4, 3'd1, 2'd2, 16'd50000);
      // out of range group and slot are dropped
      send_word(MODE_STORE, 3'd5, 3'd2, 2'd0, 16'd1000);
      send_word(MODE_STORE, 3'd7, 3'd3, 2'd1, 16'd46250);
      send_word(MODE_STORE, 3'd2, 3'd4, 2'd3, 16'd46250);
      send_word(MODE_STORE, 3'd3, 3'd1, 2'd1, 16'hFFFE);
      send_word(MODE_SCAN, 3'd0, 3'd0, 2'd0, 16'h0000);
      send_word(MODE_STORE, 3'd1, 3'd0, 2'd0, RAW_ZERO);
      send_word(MODE_STORE, 3'd0, 3'd0, 2'd1, RAW_ZERO);
      send_word(MODE_STORE, 3'd1, 3'd0, 2'd1, RAW_ZERO);
      send_word(MODE_SCAN, 3'd0, 3'd0, 2'd0, 16'h0000);
      write_scan_modules(3'd7);
      send_word(MODE_SCAN, 3'd0, 3'd0, 2'd0, 16'h0000);
      write_scan_modules(3'd0);
      send_word(MODE_SCAN, 3'd0, 3'd0, 2'd0, 16'h0000);
      send_word(MODE_STORE, 3'd4, 3'd7, 2'd1, 16'd46250);

      for (int p = 0; p < PHASES; p++) begin
         cfg = (p == 0) ? 3'd7 : (p == 1) ? 3'd0 : 3'($urandom_range(1, 7));
         write_scan_modules(cfg);
         counted = 0;
         while (counted < WORDS_PER_PHASE) begin
            m = MODE_STORE;
            g = 3'($urandom_range(0, 4));
            md = 3'($urandom_range(0, 7));
            s = 2'($urandom_range(0, 2));
            raw = 16'($urandom);
            r = $urandom_range(0, 99);
            if (r < 12) begin
               m = MODE_SCAN;
               g = 3'($urandom);
               s = 2'($urandom);
            end else if (r < 20) begin
               // broken address: group 5..7 or slot 3
               if ($urandom_range(0, 1)) g = 3'($urandom_range(5, 7));
               else s = 2'd3;
            end else begin
               r = $urandom_range(0, 99);
               if (r < 40) raw = 16'($urandom_range(30000, 56000));
               else if (r < 55) begin
                  // few distinct values so ties show up
                  case ($urandom_range(0, 3))
                     0: raw = 16'd46250;
                     1: raw = 16'd46251;
                     2: raw = 16'd50000;
                     default: raw = 16'd37500;
                  endcase
               end
               else if (r < 65) raw = 16'($urandom_range(120, 150));
               else if (r < 80) raw = 16'($urandom);
               else if (r < 86) raw = RAW_ZERO;
               else if (r < 92) raw = RAW_INVALID;
               else raw = 16'($urandom_range(62500, 65534));
            end
            useful = (m == MODE_SCAN) ||
                     (g < GROUP_COUNT && s <= SLOT_MAX && raw != RAW_INVALID &&
                      !(g == 3'd0 && raw == RAW_ZERO));
            send_word(m, g, md, s, raw);
            if (useful) counted++;
         end
      end

      start = 1'b0;
      while (in_flight != 0) @(negedge clock);
      repeat (110) @(negedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/cvs_pkg.sv
hdl/cvs_ram.sv
hdl/cvs_store.sv
hdl/cvs_scan.sv
hdl/cell_voltage_store_minmax_top.sv
dv/cell_voltage_store_minmax_scoreboard.sv
dv/cell_voltage_store_minmax_top_test.sv
